@@ sv/bfp_pkg.sv @@
// ----------------------------------------------------------------------------
// bfp_pkg
// shared types, sizes and codes of the best-fit buffer pool
// ----------------------------------------------------------------------------
package bfp_pkg;

    localparam int POOL_UNITS = 64;
    localparam int IDX_W      = $clog2(POOL_UNITS);
    localparam int CNT_W      = $clog2(POOL_UNITS + 1);
    localparam int SIZE_W     = 32;

    // request kinds
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_REALLOC = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO     = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;
    localparam logic [1:0] ST_NO_UNITS = 2'd3;

    // action codes
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_FRESH   = 3'd1;
    localparam logic [2:0] ACT_REUSED  = 3'd2;
    localparam logic [2:0] ACT_RESIZED = 3'd3;
    localparam logic [2:0] ACT_MOVED   = 3'd4;
    localparam logic [2:0] ACT_GROWN   = 3'd5;
    localparam logic [2:0] ACT_KEPT    = 3'd6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  unit_index;
        logic [31:0] request_size;
    } t_bfp_req;

    typedef struct packed {
        logic [5:0]  result_unit;
        logic [1:0]  status;
        logic [2:0]  action;
        logic [31:0] copy_length;
    } t_bfp_rsp;

    // scan token walking down the row of cells
    typedef struct packed {
        logic              vld;
        logic [SIZE_W-1:0] need;
        logic [IDX_W-1:0]  tgt;
        logic              tgt_ok;
        logic [SIZE_W-1:0] tgt_size;
        logic              bf_found;
        logic [SIZE_W-1:0] bf_size;
        logic [IDX_W-1:0]  bf_idx;
        logic              sm_found;
        logic [SIZE_W-1:0] sm_size;
        logic [IDX_W-1:0]  sm_idx;
    } t_bfp_tok;

    // update command broadcast to all cells
    typedef struct packed {
        logic              size_en;
        logic [IDX_W-1:0]  size_idx;
        logic [SIZE_W-1:0] size_val;
        logic              set_en;
        logic [IDX_W-1:0]  set_idx;
        logic              clr_en;
        logic [IDX_W-1:0]  clr_idx;
        logic              wipe_en;
        logic [CNT_W-1:0]  wipe_lo;
        logic [CNT_W-1:0]  wipe_hi;
    } t_bfp_wr;

endpackage

@@ sv/bfp_cell.sv @@
// ----------------------------------------------------------------------------
// bfp_cell
// one pool unit: holds size and in-use mark, refines the passing scan token
// ----------------------------------------------------------------------------
module bfp_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [bfp_pkg::IDX_W-1:0] i_index,
    input  logic [bfp_pkg::CNT_W-1:0] i_active,
    input  bfp_pkg::t_bfp_tok         i_tok,
    output bfp_pkg::t_bfp_tok         o_tok,
    input  bfp_pkg::t_bfp_wr          i_wr
);
    import bfp_pkg::*;

    logic [SIZE_W-1:0] r_size;
    logic              r_in_use;
    t_bfp_tok          r_tok;
    t_bfp_tok          n_tok;
    logic              w_active;
    logic              w_free;
    logic [CNT_W-1:0]  w_idx_ext;

    assign w_idx_ext = CNT_W'(i_index);
    assign w_active  = (w_idx_ext < i_active);
    assign w_free    = w_active && !r_in_use;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.tgt == i_index) begin
            n_tok.tgt_ok   = w_active && r_in_use;
            n_tok.tgt_size = r_size;
        end
        // strict compare keeps the lowest index on ties
        if (w_free && (r_size >= i_tok.need) &&
            (!i_tok.bf_found || (r_size < i_tok.bf_size))) begin
            n_tok.bf_found = 1'b1;
            n_tok.bf_size  = r_size;
            n_tok.bf_idx   = i_index;
        end
        if (w_free && (!i_tok.sm_found || (r_size < i_tok.sm_size))) begin
            n_tok.sm_found = 1'b1;
            n_tok.sm_size  = r_size;
            n_tok.sm_idx   = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= '0;
            r_size   <= '0;
            r_in_use <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_wr.wipe_en && (w_idx_ext >= i_wr.wipe_lo) && (w_idx_ext < i_wr.wipe_hi)) begin
                r_size   <= '0;
                r_in_use <= 1'b0;
            end
            if (i_wr.size_en && (i_wr.size_idx == i_index)) begin
                r_size <= i_wr.size_val;
            end
            if (i_wr.set_en && (i_wr.set_idx == i_index)) begin
                r_in_use <= 1'b1;
            end
            if (i_wr.clr_en && (i_wr.clr_idx == i_index)) begin
                r_in_use <= 1'b0;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

@@ sv/best_fit_buffer_pool_unit.sv @@
// ----------------------------------------------------------------------------
// best_fit_buffer_pool_unit
// best-fit allocator over a pool of indexed buffer units
// ----------------------------------------------------------------------------
// flow: the request is registered, its scan token walks the row of unit cells
//   one cell per cycle, the result is held, then committed to the output register
//   once the output is free; no new request is taken until that commit
// a new request is taken while the previous result still waits on the output
// reset (synchronous, active low) empties the pool: all sizes zero, no unit
//   in use, no active units
module best_fit_buffer_pool_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  bfp_pkg::t_bfp_req i_req,
    output logic              o_valid,
    input  logic              i_stall,
    output bfp_pkg::t_bfp_rsp o_rsp
);
    import bfp_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    t_bfp_req         r_req;
    logic             r_go;
    t_bfp_tok         r_fin;
    logic [CNT_W-1:0] r_active;
    logic [CNT_W-1:0] n_active;
    logic [CNT_W-1:0] r_busy;
    logic [CNT_W-1:0] n_busy;
    logic             r_ovalid;
    t_bfp_rsp         r_rsp;

    t_bfp_tok         w_tok [0:POOL_UNITS];
    t_bfp_wr          w_wr;
    t_bfp_wr          w_cmd;
    t_bfp_rsp         w_rsp;
    logic             w_in_xfer;
    logic             w_out_free;
    logic             w_commit;
    logic             w_inc;
    logic             w_dec;
    logic [CNT_W-1:0] w_grown;
    logic [CNT_W:0]   w_dbl;

    assign w_in_xfer  = i_valid && !o_stall;
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_commit   = (r_state == S_DONE) && w_out_free;

    // launch token: fresh candidates, target index and size to cover
    always_comb begin
        w_tok[0]      = '0;
        w_tok[0].vld  = r_go;
        w_tok[0].need = r_req.request_size;
        w_tok[0].tgt  = r_req.unit_index;
    end

    // row of unit cells, token moves one cell per cycle
    for (genvar g = 0; g < POOL_UNITS; g++) begin : g_cell
        bfp_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (IDX_W'(g)),
            .i_active (r_active),
            .i_tok    (w_tok[g]),
            .o_tok    (w_tok[g+1]),
            .i_wr     (w_wr)
        );
    end

    // pool growth: 0 -> 1, else double, capped at the pool size
    assign w_dbl = {r_active, 1'b0};
    always_comb begin
        if (r_active == '0) begin
            w_grown = CNT_W'(1);
        end else if (w_dbl > (CNT_W+1)'(POOL_UNITS)) begin
            w_grown = CNT_W'(POOL_UNITS);
        end else begin
            w_grown = w_dbl[CNT_W-1:0];
        end
    end

    // decision from the finished scan
    always_comb begin
        w_rsp = '0;
        w_cmd = '0;
        w_inc = 1'b0;
        w_dec = 1'b0;
        n_active = r_active;
        unique case (r_req.req_type) inside
            REQ_ALLOC: begin
                if (r_req.request_size == '0) begin
                    w_rsp.status = ST_ZERO;
                end else if (r_busy >= r_active) begin
                    if (r_active >= CNT_W'(POOL_UNITS)) begin
                        w_rsp.status = ST_NO_UNITS;
                    end else begin
                        // first new unit is granted, the rest come up empty
                        n_active       = w_grown;
                        w_cmd.size_en  = 1'b1;
                        w_cmd.size_idx = r_active[IDX_W-1:0];
                        w_cmd.size_val = r_req.request_size;
                        w_cmd.set_en   = 1'b1;
                        w_cmd.set_idx  = r_active[IDX_W-1:0];
                        w_cmd.wipe_en  = 1'b1;
                        w_cmd.wipe_lo  = r_active + CNT_W'(1);
                        w_cmd.wipe_hi  = w_grown;
                        w_inc          = 1'b1;
                        w_rsp.result_unit = r_active[IDX_W-1:0];
                        w_rsp.action      = ACT_FRESH;
                    end
                end else if (r_fin.bf_found) begin
                    w_cmd.set_en      = 1'b1;
                    w_cmd.set_idx     = r_fin.bf_idx;
                    w_inc             = 1'b1;
                    w_rsp.result_unit = r_fin.bf_idx;
                    w_rsp.action      = ACT_REUSED;
                end else if (r_fin.sm_found) begin
                    // nothing covers it: resize the smallest free unit
                    w_cmd.set_en      = 1'b1;
                    w_cmd.set_idx     = r_fin.sm_idx;
                    w_cmd.size_en     = 1'b1;
                    w_cmd.size_idx    = r_fin.sm_idx;
                    w_cmd.size_val    = r_req.request_size;
                    w_inc             = 1'b1;
                    w_rsp.result_unit = r_fin.sm_idx;
                    w_rsp.action      = ACT_RESIZED;
                end else begin
                    w_rsp.status = ST_NO_UNITS;
                end
            end
            REQ_FREE, REQ_REALLOC: begin
                w_rsp.result_unit = r_req.unit_index;
                if (!r_fin.tgt_ok) begin
                    w_rsp.status = ST_INVALID;
                end else if ((r_req.req_type == REQ_FREE) || (r_req.request_size == '0)) begin
                    // reallocate to size zero behaves as free
                    w_cmd.clr_en  = 1'b1;
                    w_cmd.clr_idx = r_req.unit_index;
                    w_dec         = 1'b1;
                end else if (r_req.request_size <= r_fin.tgt_size) begin
                    w_rsp.action = ACT_KEPT;
                end else if ((r_busy != r_active) && r_fin.bf_found) begin
                    // move: caller copies the old contents
                    w_cmd.clr_en      = 1'b1;
                    w_cmd.clr_idx     = r_req.unit_index;
                    w_cmd.set_en      = 1'b1;
                    w_cmd.set_idx     = r_fin.bf_idx;
                    w_rsp.result_unit = r_fin.bf_idx;
                    w_rsp.action      = ACT_MOVED;
                    w_rsp.copy_length = r_fin.tgt_size;
                end else begin
                    w_cmd.size_en  = 1'b1;
                    w_cmd.size_idx = r_req.unit_index;
                    w_cmd.size_val = r_req.request_size;
                    w_rsp.action   = ACT_GROWN;
                end
            end
            default: begin
                w_rsp.status = ST_INVALID;
            end
        endcase
    end

    // cells only see the command in the commit cycle
    always_comb begin
        w_wr = '0;
        if (w_commit) begin
            w_wr = w_cmd;
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (w_commit && w_inc) begin
            n_busy = r_busy + CNT_W'(1);
        end else if (w_commit && w_dec) begin
            n_busy = r_busy - CNT_W'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_tok[POOL_UNITS].vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_go     <= 1'b0;
            r_active <= '0;
            r_busy   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= w_in_xfer;
            r_busy  <= n_busy;
            if (w_commit) begin
                r_active <= n_active;
            end
            if (w_commit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_req <= i_req;
        end
        if (w_tok[POOL_UNITS].vld) begin
            r_fin <= w_tok[POOL_UNITS];
        end
        if (w_commit) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

endmodule

@@ tb/bfp_pool_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfp_pool_checker
// watches both channels of the buffer pool, predicts every grant from its
// own copy of the pool and compares each result transfer field by field
// ----------------------------------------------------------------------------
module bfp_pool_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    input  logic                             i_req_stall,
    input  bfp_pkg::t_bfp_req                i_req,
    input  logic                             i_rsp_valid,
    input  logic                             i_rsp_stall,
    input  bfp_pkg::t_bfp_rsp                i_rsp,
    output int                               o_fail_count,
    output int                               o_waiting,
    output logic [bfp_pkg::POOL_UNITS-1:0]   o_busy_map
);
    import bfp_pkg::*;

    // shadow pool
    logic [SIZE_W-1:0]     pool_bytes [POOL_UNITS];
    logic [POOL_UNITS-1:0] pool_taken;
    int                    live_units;
    int                    taken_units;

    t_bfp_rsp grant_q [$];
    int       fail_total;

    assign o_fail_count = fail_total;
    assign o_busy_map   = pool_taken;

    function automatic bit unit_held(input int idx);
        return idx < live_units && pool_taken[idx];
    endfunction

    // smallest free live unit that covers need, lowest index on ties
    function automatic bit best_free_fit(input logic [SIZE_W-1:0] need, output int pick);
        bit found;
        int i;
        found = 1'b0;
        pick  = 0;
        for (i = 0; i < live_units; i++) begin
            if (!pool_taken[i] && pool_bytes[i] >= need) begin
                if (!found || pool_bytes[i] < pool_bytes[pick]) begin
                    pick  = i;
                    found = 1'b1;
                end
            end
        end
        return found;
    endfunction

    function automatic t_bfp_rsp release_unit(input int idx);
        t_bfp_rsp rsp;
        rsp             = '0;
        rsp.result_unit = IDX_W'(idx);
        if (!unit_held(idx)) begin
            rsp.status = ST_INVALID;
        end else begin
            pool_taken[idx] = 1'b0;
            taken_units--;
        end
        return rsp;
    endfunction

    function automatic t_bfp_rsp pool_respond(input t_bfp_req r);
        t_bfp_rsp rsp;
        int       pick;
        int       old_live;
        int       grown;
        int       idx;
        int       i;
        rsp = '0;
        idx = int'(r.unit_index);
        case (r.req_type)
            REQ_ALLOC: begin
                if (r.request_size == '0) begin
                    rsp.status = ST_ZERO;
                end else if (taken_units >= live_units) begin
                    if (live_units >= POOL_UNITS) begin
                        rsp.status = ST_NO_UNITS;
                    end else begin
                        // pool full: double the live range, grant the first new unit
                        old_live = live_units;
                        grown    = (old_live == 0) ? 1 : old_live * 2;
                        if (grown > POOL_UNITS) grown = POOL_UNITS;
                        for (i = old_live + 1; i < grown; i++) begin
                            pool_bytes[i] = '0;
                            pool_taken[i] = 1'b0;
                        end
                        live_units           = grown;
                        pool_bytes[old_live] = r.request_size;
                        pool_taken[old_live] = 1'b1;
                        taken_units++;
                        rsp.result_unit = IDX_W'(old_live);
                        rsp.action      = ACT_FRESH;
                    end
                end else if (best_free_fit(r.request_size, pick)) begin
                    pool_taken[pick] = 1'b1;
                    taken_units++;
                    rsp.result_unit = IDX_W'(pick);
                    rsp.action      = ACT_REUSED;
                end else begin
                    // nothing covers it: take over the smallest free unit
                    pick = -1;
                    for (i = 0; i < live_units; i++) begin
                        if (!pool_taken[i] && (pick < 0 || pool_bytes[i] < pool_bytes[pick]))
                            pick = i;
                    end
                    if (pick < 0) begin
                        rsp.status = ST_NO_UNITS;
                    end else begin
                        pool_taken[pick] = 1'b1;
                        pool_bytes[pick] = r.request_size;
                        taken_units++;
                        rsp.result_unit = IDX_W'(pick);
                        rsp.action      = ACT_RESIZED;
                    end
                end
            end
            REQ_FREE: begin
                rsp = release_unit(idx);
            end
            REQ_REALLOC: begin
                rsp.result_unit = IDX_W'(idx);
                if (r.request_size == '0) begin
                    rsp = release_unit(idx);
                end else if (!unit_held(idx)) begin
                    rsp.status = ST_INVALID;
                end else if (r.request_size <= pool_bytes[idx]) begin
                    rsp.action = ACT_KEPT;
                end else if (taken_units != live_units
                             && best_free_fit(r.request_size, pick)) begin
                    pool_taken[idx]  = 1'b0;
                    pool_taken[pick] = 1'b1;
                    rsp.result_unit  = IDX_W'(pick);
                    rsp.action       = ACT_MOVED;
                    rsp.copy_length  = pool_bytes[idx];
                end else begin
                    pool_bytes[idx] = r.request_size;
                    rsp.action      = ACT_GROWN;
                end
            end
            default: begin
                rsp.status = ST_INVALID;
            end
        endcase
        return rsp;
    endfunction

    task automatic check_field(input string what, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_bfp_rsp want;
        int       i;
        if (!i_rst_n) begin
            for (i = 0; i < POOL_UNITS; i++) pool_bytes[i] = '0;
            pool_taken  = '0;
            live_units  = 0;
            taken_units = 0;
            fail_total  = 0;
            grant_q.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (grant_q.size() == 0) begin
                    fail_total++;
                    $display({"%0t: result with nothing expected, expected none, ",
                              "actual unit %0d status %0d action %0d"},
                             $time, i_rsp.result_unit, i_rsp.status, i_rsp.action);
                end else begin
                    want = grant_q.pop_front();
                    check_field("result_unit", 64'(want.result_unit),
                                64'(i_rsp.result_unit));
                    check_field("status", 64'(want.status), 64'(i_rsp.status));
                    check_field("action", 64'(want.action), 64'(i_rsp.action));
                    check_field("copy_length", 64'(want.copy_length),
                                64'(i_rsp.copy_length));
                end
            end
            if (i_req_valid && !i_req_stall) grant_q.push_back(pool_respond(i_req));
        end
        o_waiting = grant_q.size();
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives allocate, free and reallocate requests into the buffer pool, with
// random gaps and output stalls, and reports the checker's verdict
// ----------------------------------------------------------------------------
module tb_top;
    import bfp_pkg::*;

    // the one request code the package leaves unnamed
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    localparam int BLOCK_ITEMS  = 50;      // random requests per block
    localparam int RAND_BLOCKS  = 23;
    localparam int CALM_BLOCKS  = 3;       // trailing blocks without idling
    localparam int QUIET_LIMIT  = 2000;    // cycles without any transfer

    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    t_bfp_req req       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    t_bfp_rsp rsp;

    int                    fail_count;
    int                    waiting;
    logic [POOL_UNITS-1:0] busy_map;

    bit idling_on  = 1'b1;
    int stall_left = 0;

    best_fit_buffer_pool_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (req_valid),
        .o_stall (req_stall),
        .i_req   (req),
        .o_valid (rsp_valid),
        .i_stall (rsp_stall),
        .o_rsp   (rsp)
    );

    bfp_pool_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_req        (req),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_stall  (rsp_stall),
        .i_rsp        (rsp),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .o_busy_map   (busy_map)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // receiver side: random stall bursts while idling is on
    always @(negedge i_clk) begin
        if (!idling_on) begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 6) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 18);
        end else begin
            rsp_stall <= 1'b0;
        end
    end

    // watchdog: any run of cycles with no transfer on either channel is bounded
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
            else quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_bfp_req make_req(input logic [1:0] kind, input int idx,
                                          input logic [SIZE_W-1:0] size);
        t_bfp_req r;
        r.req_type     = kind;
        r.unit_index   = IDX_W'(idx);
        r.request_size = size;
        return r;
    endfunction

    // one request transfer, entered and left at a falling edge; an optional
    // sender gap comes first, payload holds until the block takes it
    task automatic issue(input t_bfp_req r);
        if (idling_on && $urandom_range(0, 99) < 12) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge i_clk); while (req_stall);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_bfp_req r;
        int       blk;
        int       n;
        int       alloc_pct;
        int       roll;
        int       probe;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed walk through the special cases on an empty pool
        issue(make_req(REQ_ALLOC, 0, 32'd0));             // zero-size allocate
        issue(make_req(REQ_FREE, 0, 32'd7));              // free before any unit is live
        issue(make_req(REQ_REALLOC, 5, 32'd10));          // reallocate of an inactive unit
        issue(make_req(REQ_UNKNOWN, 63, 32'hFFFF_FFFF));  // unknown request kind
        issue(make_req(REQ_ALLOC, 63, 32'd1));            // first growth: unit 0 fresh
        issue(make_req(REQ_ALLOC, 0, 32'hFFFF_FFFF));     // growth to 2 units, max size
        issue(make_req(REQ_ALLOC, 21, 32'd8));            // growth to 4, unit 3 left empty
        issue(make_req(REQ_ALLOC, 42, 32'd3));            // no free cover: resize unit 3
        issue(make_req(REQ_FREE, 2, 32'd0));
        issue(make_req(REQ_FREE, 2, 32'd0));              // double free of an unused unit
        issue(make_req(REQ_ALLOC, 0, 32'd6));             // best fit reuses unit 2
        issue(make_req(REQ_REALLOC, 2, 32'd4));           // shrink: kept
        issue(make_req(REQ_FREE, 1, 32'd0));
        issue(make_req(REQ_REALLOC, 0, 32'd100));         // moves into unit 1, copy 1 byte
        issue(make_req(REQ_REALLOC, 3, 32'd50));          // nothing covers: grown in place
        issue(make_req(REQ_REALLOC, 2, 32'd0));           // zero-size reallocate frees
        issue(make_req(REQ_REALLOC, 2, 32'd0));           // and again on an unused unit
        issue(make_req(REQ_FREE, 63, 32'hFFFF_FFFF));     // free of an inactive unit
        issue(make_req(REQ_ALLOC, 9, 32'd8));             // best fit picks unit 2 over unit 0
        issue(make_req(REQ_FREE, 3, 32'd0));
        issue(make_req(REQ_ALLOC, 9, 32'd1));

        // random blocks, each with its own mix; the first ones fill the pool
        for (blk = 0; blk < RAND_BLOCKS; blk++) begin
            case ($urandom_range(0, 3))
                0:       alloc_pct = 90;
                1:       alloc_pct = 65;
                2:       alloc_pct = 45;
                default: alloc_pct = 25;
            endcase
            if (blk < 3) alloc_pct = 90;
            idling_on = (blk < RAND_BLOCKS - CALM_BLOCKS) && ($urandom_range(0, 3) != 0);

            // hold off once until every grant has come back
            if (blk == RAND_BLOCKS / 2) begin
                req_valid <= 1'b0;
                wait (waiting == 0);
                @(negedge i_clk);
            end

            for (n = 0; n < BLOCK_ITEMS; n++) begin
                r.unit_index = IDX_W'($urandom_range(0, POOL_UNITS - 1));
                roll         = $urandom_range(0, 99);
                // sizes stay small so fits, ties and resizes happen often
                if (roll < 4)       r.request_size = '0;
                else if (roll < 8)  r.request_size = 32'hFFFF_FFFF;
                else if (roll < 18) r.request_size = $urandom;
                else if (roll < 40) r.request_size = $urandom_range(1, 1000);
                else                r.request_size = $urandom_range(1, 48);

                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    r.req_type = REQ_UNKNOWN;
                end else if (roll < alloc_pct) begin
                    r.req_type = REQ_ALLOC;
                end else begin
                    r.req_type = ($urandom_range(0, 1) != 0) ? REQ_FREE : REQ_REALLOC;
                    // mostly aim at a unit that is really held
                    if (busy_map != '0 && $urandom_range(0, 99) < 85) begin
                        probe = $urandom_range(0, POOL_UNITS - 1);
                        while (!busy_map[probe]) probe = (probe + 1) % POOL_UNITS;
                        r.unit_index = IDX_W'(probe);
                    end
                end
                issue(r);
            end
        end

        req_valid <= 1'b0;
        wait (waiting == 0);
        // a little longer than one pass of the scan, to catch stray results
        repeat (POOL_UNITS + 16) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
